// ----- sv/multitap_key_composer_top_macros.svh -----
// Assertion macros for the multi-tap key composer
`ifndef MULTITAP_KEY_COMPOSER_TOP_MACROS_SVH
`define MULTITAP_KEY_COMPOSER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk, off while rst_n is low
`define MKC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low
`define MKC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MKC_ASSERT_IMPL(label, ante, cons, msg)
`define MKC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- sv/mkc_pkg.sv -----
// Shared constants, codes and helpers of the multi-tap key composer
`default_nettype none

package mkc_pkg;

    localparam int MAX_KEYS  = 16;
    localparam int MAX_CHARS = 8;

    // Fixed field widths
    localparam int OP_W       = 3;
    localparam int KEY_W      = 32;
    localparam int CHAR_W     = 21;
    localparam int SLOT_IN_W  = 4;
    localparam int CIDX_IN_W  = 3;
    localparam int LEN_W      = 4;
    localparam int TIMER_W    = 16;
    localparam int KEYS_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Derived widths
    localparam int SLOT_AW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CHAR_AW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int CAND_AW    = SLOT_AW + CHAR_AW;
    localparam int CAND_DEPTH = MAX_KEYS << CHAR_AW;
    localparam int SCAN_W     = $clog2(MAX_KEYS + 1);
    localparam int PCNT_W     = $clog2(MAX_CHARS + 1);

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(1000);

    // Input operation codes
    localparam logic [OP_W-1:0] OP_PRESS = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYS    = 1'd1;

    // Result kinds
    localparam logic KIND_COMMIT = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef logic [PCNT_W-1:0] pcnt_t;

    // Sequence length clamped to the candidate count
    function automatic pcnt_t eff_len(input logic [LEN_W-1:0] len);
        pcnt_t res;
        if (int'(len) > MAX_CHARS)
        begin
            res = PCNT_W'(MAX_CHARS);
        end
        else
        begin
            res = PCNT_W'(len);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mkc_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module mkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/multitap_key_composer_top.sv -----
// Multi-tap keypad composer: key table memories, lookup sequencer and result register
//
// Usage: load the key table first with load items (op 4), one candidate code point
// per item; candidate 0 of a slot also sets the slot's key. Set keys_in_use and
// timeout_ticks through the cfg_valid/cfg_ready write port (always ready) while idle.
// Input items (in_valid/in_stall) are key presses, other key events, ticks, resets
// and loads. Each item yields zero to two commit items followed by one status item
// (last = 1) on the out_valid/out_stall channel.
// One item at a time: a new item is taken only once the last one is done. A key
// press walks the table one slot per cycle; the candidate memory read port sets
// the scan rate, as a slot key is its candidate 0.
// in_stall stays high until the status item has been loaded into the output
// register. A stalled receiver holds the output register and the sequencer waits
// on it; nothing is dropped.
// Reset clears the pending candidate, stops the timer, sets timeout_ticks to 1000
// and keys_in_use to 0. The table memories are not cleared and must be loaded.
`default_nettype none
`include "multitap_key_composer_top_macros.svh"

module multitap_key_composer_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [mkc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mkc_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [mkc_pkg::OP_W-1:0]         op,
    input  wire logic [mkc_pkg::KEY_W-1:0]        key_code,
    input  wire logic [mkc_pkg::CHAR_W-1:0]       key_char,
    input  wire logic                             passthrough,
    input  wire logic [mkc_pkg::SLOT_IN_W-1:0]    slot_index,
    input  wire logic [mkc_pkg::CIDX_IN_W-1:0]    char_index,
    input  wire logic [mkc_pkg::CHAR_W-1:0]       table_char,
    input  wire logic [mkc_pkg::LEN_W-1:0]        seq_length,
    // result items
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  kind,
    output logic      [mkc_pkg::CHAR_W-1:0]       char_code,
    output logic                                  handled,
    output logic      [mkc_pkg::CHAR_W-1:0]       preedit_code,
    output logic                                  preedit_valid,
    output logic                                  last
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PRE    = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_CAND   = 3'd3;
    localparam logic [2:0] ST_MISS   = 3'd4;
    localparam logic [2:0] ST_STATUS = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [mkc_pkg::TIMER_W-1:0] timeout_reg, timeout_next;
    logic [mkc_pkg::KEYS_W-1:0]  keys_in_use_reg, keys_in_use_next;

    logic [mkc_pkg::KEY_W-1:0]   last_key_reg, last_key_next;
    mkc_pkg::pcnt_t              press_reg, press_next;
    logic [mkc_pkg::CHAR_W-1:0]  pend_char_reg, pend_char_next;
    logic                        pend_valid_reg, pend_valid_next;
    logic [mkc_pkg::TIMER_W-1:0] ticks_reg, ticks_next;

    logic [mkc_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [mkc_pkg::CHAR_W-1:0]  kch_reg, kch_next;
    logic                        pass_reg, pass_next;
    logic                        press_op_reg, press_op_next;
    logic                        handled_item_reg, handled_item_next;

    logic [mkc_pkg::SCAN_W-1:0]  scan_reg, scan_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [mkc_pkg::SLOT_AW-1:0] cmp_slot_reg, cmp_slot_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        kind_reg, kind_next;
    logic [mkc_pkg::CHAR_W-1:0]  char_code_reg, char_code_next;
    logic                        handled_reg, handled_next;
    logic [mkc_pkg::CHAR_W-1:0]  preedit_code_reg, preedit_code_next;
    logic                        preedit_valid_reg, preedit_valid_next;
    logic                        last_reg, last_next;

    // memory ports
    logic                        len_we, cand_we, key_re, cand_re;
    logic [mkc_pkg::SLOT_AW-1:0] slot_waddr;
    logic [mkc_pkg::CAND_AW-1:0] cand_waddr, cand_raddr;
    logic [mkc_pkg::LEN_W-1:0]   len_rd;
    logic [mkc_pkg::CHAR_W-1:0]  cand_rd;

    logic                        in_accept, can_load, load_ok, scan_hit;
    logic [mkc_pkg::SCAN_W-1:0]  lim;
    mkc_pkg::pcnt_t              hit_len, pc_base;
    logic [mkc_pkg::TIMER_W-1:0] tick_load;

    logic                        emit_en, emit_kind;
    logic [mkc_pkg::CHAR_W-1:0]  emit_char;

    mkc_ram #(.WIDTH(mkc_pkg::LEN_W), .DEPTH(mkc_pkg::MAX_KEYS)) u_len_ram (
        .clk   (clk),
        .we    (len_we),
        .waddr (slot_waddr),
        .wdata (seq_length),
        .re    (key_re),
        .raddr (scan_reg[mkc_pkg::SLOT_AW-1:0]),
        .rdata (len_rd)
    );

    mkc_ram #(.WIDTH(mkc_pkg::CHAR_W), .DEPTH(mkc_pkg::CAND_DEPTH)) u_cand_ram (
        .clk   (clk),
        .we    (cand_we),
        .waddr (cand_waddr),
        .wdata (table_char),
        .re    (key_re || cand_re),
        .raddr (cand_raddr),
        .rdata (cand_rd)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign can_load  = !out_valid_reg || !out_stall;

    assign slot_waddr = mkc_pkg::SLOT_AW'(slot_index);
    assign cand_waddr = {mkc_pkg::SLOT_AW'(slot_index), mkc_pkg::CHAR_AW'(char_index)};
    assign load_ok    = (int'(slot_index) < mkc_pkg::MAX_KEYS)
                        && (int'(char_index) < mkc_pkg::MAX_CHARS);

    assign lim = (int'(keys_in_use_reg) > mkc_pkg::MAX_KEYS)
                 ? mkc_pkg::SCAN_W'(mkc_pkg::MAX_KEYS)
                 : mkc_pkg::SCAN_W'(keys_in_use_reg);

    assign hit_len  = mkc_pkg::eff_len(len_rd);
    assign scan_hit = cmp_valid_reg && (mkc_pkg::KEY_W'(cand_rd) == key_reg)
                      && (len_rd != '0);
    // wrap to the first candidate once the sequence is used up
    assign pc_base  = (press_reg >= hit_len) ? '0 : press_reg;
    // the slot key is candidate 0 of its slot
    assign cand_raddr = key_re
                        ? {scan_reg[mkc_pkg::SLOT_AW-1:0], {mkc_pkg::CHAR_AW{1'b0}}}
                        : {cmp_slot_reg, mkc_pkg::CHAR_AW'(pc_base)};
    assign tick_load  = (timeout_reg == '0) ? mkc_pkg::TIMER_W'(1) : timeout_reg;

    always_comb
    begin
        state_next        = state_reg;
        timeout_next      = timeout_reg;
        keys_in_use_next  = keys_in_use_reg;
        last_key_next     = last_key_reg;
        press_next        = press_reg;
        pend_char_next    = pend_char_reg;
        pend_valid_next   = pend_valid_reg;
        ticks_next        = ticks_reg;
        key_next          = key_reg;
        kch_next          = kch_reg;
        pass_next         = pass_reg;
        press_op_next     = press_op_reg;
        handled_item_next = handled_item_reg;
        scan_next         = scan_reg;
        cmp_valid_next    = 1'b0;
        cmp_slot_next     = cmp_slot_reg;
        len_we            = 1'b0;
        cand_we           = 1'b0;
        key_re            = 1'b0;
        cand_re           = 1'b0;
        emit_en           = 1'b0;
        emit_kind         = mkc_pkg::KIND_STATUS;
        emit_char         = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mkc_pkg::CFG_TIMEOUT: timeout_next = mkc_pkg::TIMER_W'(cfg_data);
                mkc_pkg::CFG_KEYS:    keys_in_use_next = mkc_pkg::KEYS_W'(cfg_data);
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                scan_next = '0;
                if (in_accept)
                begin
                    key_next          = key_code;
                    kch_next          = key_char;
                    pass_next         = passthrough;
                    press_op_next     = (op == mkc_pkg::OP_PRESS);
                    handled_item_next = 1'b0;
                    state_next        = ST_STATUS;
                    case (op)
                        mkc_pkg::OP_PRESS:
                        begin
                            // a different key commits the pending candidate first
                            if (pend_valid_reg && (press_reg != '0)
                                && (last_key_reg != key_code))
                            begin
                                state_next = ST_PRE;
                            end
                            else if (passthrough)
                            begin
                                state_next = ST_MISS;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        mkc_pkg::OP_TICK:
                        begin
                            if (ticks_reg != '0)
                            begin
                                ticks_next = ticks_reg - 1'b1;
                                if (ticks_reg == mkc_pkg::TIMER_W'(1))
                                begin
                                    if (pend_valid_reg)
                                    begin
                                        state_next = ST_PRE;
                                    end
                                    else
                                    begin
                                        last_key_next   = '0;
                                        press_next      = '0;
                                        pend_char_next  = '0;
                                        pend_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        mkc_pkg::OP_RESET:
                        begin
                            last_key_next   = '0;
                            press_next      = '0;
                            pend_char_next  = '0;
                            pend_valid_next = 1'b0;
                            ticks_next      = '0;
                        end
                        mkc_pkg::OP_LOAD:
                        begin
                            if (load_ok)
                            begin
                                cand_we = 1'b1;
                                len_we  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_PRE:
            begin
                if (can_load)
                begin
                    emit_en         = 1'b1;
                    emit_kind       = mkc_pkg::KIND_COMMIT;
                    emit_char       = pend_char_reg;
                    last_key_next   = '0;
                    press_next      = '0;
                    pend_char_next  = '0;
                    pend_valid_next = 1'b0;
                    ticks_next      = '0;
                    if (!press_op_reg)
                    begin
                        state_next = ST_STATUS;
                    end
                    else if (pass_reg)
                    begin
                        state_next = ST_MISS;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // compare the slot read last cycle while the next one is read
                if (scan_hit)
                begin
                    cand_re           = 1'b1;
                    press_next        = pc_base + 1'b1;
                    last_key_next     = key_reg;
                    ticks_next        = tick_load;
                    handled_item_next = 1'b1;
                    state_next        = ST_CAND;
                end
                else if (scan_reg == lim)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    key_re         = 1'b1;
                    scan_next      = scan_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_slot_next  = mkc_pkg::SLOT_AW'(scan_reg);
                end
            end

            ST_CAND:
            begin
                pend_char_next  = cand_rd;
                pend_valid_next = 1'b1;
                state_next      = ST_STATUS;
            end

            ST_MISS:
            begin
                if (pend_valid_reg && (press_reg != '0))
                begin
                    if (can_load)
                    begin
                        emit_en         = 1'b1;
                        emit_kind       = mkc_pkg::KIND_COMMIT;
                        emit_char       = pend_char_reg;
                        last_key_next   = '0;
                        press_next      = '0;
                        pend_char_next  = '0;
                        pend_valid_next = 1'b0;
                        ticks_next      = '0;
                    end
                end
                else if (kch_reg != '0)
                begin
                    if (can_load)
                    begin
                        emit_en           = 1'b1;
                        emit_kind         = mkc_pkg::KIND_COMMIT;
                        emit_char         = kch_reg;
                        last_key_next     = '0;
                        press_next        = '0;
                        pend_char_next    = '0;
                        pend_valid_next   = 1'b0;
                        ticks_next        = '0;
                        handled_item_next = 1'b1;
                        state_next        = ST_STATUS;
                    end
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end

            ST_STATUS:
            begin
                if (can_load)
                begin
                    emit_en    = 1'b1;
                    emit_kind  = mkc_pkg::KIND_STATUS;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register: drop when taken, load when an item is emitted
    always_comb
    begin
        out_valid_next     = out_valid_reg && out_stall;
        kind_next          = kind_reg;
        char_code_next     = char_code_reg;
        handled_next       = handled_reg;
        preedit_code_next  = preedit_code_reg;
        preedit_valid_next = preedit_valid_reg;
        last_next          = last_reg;
        if (emit_en)
        begin
            out_valid_next = 1'b1;
            kind_next      = emit_kind;
            if (emit_kind == mkc_pkg::KIND_COMMIT)
            begin
                char_code_next     = emit_char;
                handled_next       = 1'b0;
                preedit_code_next  = '0;
                preedit_valid_next = 1'b0;
                last_next          = 1'b0;
            end
            else
            begin
                char_code_next     = '0;
                handled_next       = handled_item_reg;
                preedit_code_next  = pend_valid_reg ? pend_char_reg : '0;
                preedit_valid_next = pend_valid_reg;
                last_next          = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            timeout_reg      <= mkc_pkg::TIMEOUT_RESET;
            keys_in_use_reg  <= '0;
            last_key_reg     <= '0;
            press_reg        <= '0;
            pend_char_reg    <= '0;
            pend_valid_reg   <= 1'b0;
            ticks_reg        <= '0;
            handled_item_reg <= 1'b0;
            scan_reg         <= '0;
            cmp_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            timeout_reg      <= timeout_next;
            keys_in_use_reg  <= keys_in_use_next;
            last_key_reg     <= last_key_next;
            press_reg        <= press_next;
            pend_char_reg    <= pend_char_next;
            pend_valid_reg   <= pend_valid_next;
            ticks_reg        <= ticks_next;
            handled_item_reg <= handled_item_next;
            scan_reg         <= scan_next;
            cmp_valid_reg    <= cmp_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg           <= key_next;
        kch_reg           <= kch_next;
        pass_reg          <= pass_next;
        press_op_reg      <= press_op_next;
        cmp_slot_reg      <= cmp_slot_next;
        kind_reg          <= kind_next;
        char_code_reg     <= char_code_next;
        handled_reg       <= handled_next;
        preedit_code_reg  <= preedit_code_next;
        preedit_valid_reg <= preedit_valid_next;
        last_reg          <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign char_code     = char_code_reg;
    assign handled       = handled_reg;
    assign preedit_code  = preedit_code_reg;
    assign preedit_valid = preedit_valid_reg;
    assign last          = last_reg;

    `MKC_ASSERT_IMPL(a_pend_matches_count, (state_reg != ST_CAND), (pend_valid_reg == (press_reg != '0)), "pending flag and press count disagree")
    `MKC_ASSERT_IMPL(a_timer_needs_pending, (ticks_reg != '0) && (state_reg != ST_CAND), pend_valid_reg, "timer running without a pending candidate")
    `MKC_ASSERT_IMPL(a_scan_in_range, (state_reg == ST_SCAN), (scan_reg <= lim), "key scan ran past the slot limit")
    `MKC_ASSERT_IMPL(a_commit_clean, out_valid_reg && (kind_reg == mkc_pkg::KIND_COMMIT), (!handled_reg && !preedit_valid_reg && !last_reg), "commit item carries status fields")
    `MKC_ASSERT_NEXT(a_hit_loads_cand, (state_reg == ST_SCAN) && scan_hit, (state_reg == ST_CAND), "table hit did not read the candidate")

endmodule

`default_nettype wire

// ----- bench/multitap_key_composer_top_test.sv -----
// Self-checking testbench for the multi-tap key composer: directed cases, random traffic
`timescale 1ns / 100ps

module multitap_key_composer_top_test;

    localparam int CLK_HALF    = 5;
    localparam int DRAIN_PAUSE = 30;
    localparam int LONG_HOLD   = 250;
    localparam int PHASE_ITEMS = 50;

    // Codes the package leaves unnamed
    localparam logic [mkc_pkg::OP_W-1:0] OP_OTHER    = 3'd1;
    localparam logic [mkc_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [mkc_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [mkc_pkg::OP_W-1:0]      op;
        logic [mkc_pkg::KEY_W-1:0]     key_code;
        logic [mkc_pkg::CHAR_W-1:0]    key_char;
        logic                          passthrough;
        logic [mkc_pkg::SLOT_IN_W-1:0] slot_index;
        logic [mkc_pkg::CIDX_IN_W-1:0] char_index;
        logic [mkc_pkg::CHAR_W-1:0]    table_char;
        logic [mkc_pkg::LEN_W-1:0]     seq_length;
    } key_event_t;

    typedef struct packed {
        logic                       kind;
        logic [mkc_pkg::CHAR_W-1:0] char_code;
        logic                       handled;
        logic [mkc_pkg::CHAR_W-1:0] preedit_code;
        logic                       preedit_valid;
        logic                       last;
    } composer_out_t;

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              cfg_valid   = 1'b0;
    logic                              cfg_ready;
    logic [mkc_pkg::CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [mkc_pkg::CFG_DATA_W-1:0]    cfg_data    = '0;
    logic                              in_valid    = 1'b0;
    logic                              in_stall;
    logic [mkc_pkg::OP_W-1:0]          op          = '0;
    logic [mkc_pkg::KEY_W-1:0]         key_code    = '0;
    logic [mkc_pkg::CHAR_W-1:0]        key_char    = '0;
    logic                              passthrough = 1'b0;
    logic [mkc_pkg::SLOT_IN_W-1:0]     slot_index  = '0;
    logic [mkc_pkg::CIDX_IN_W-1:0]     char_index  = '0;
    logic [mkc_pkg::CHAR_W-1:0]        table_char  = '0;
    logic [mkc_pkg::LEN_W-1:0]         seq_length  = '0;
    logic                              out_valid;
    logic                              out_stall   = 1'b0;
    logic                              kind;
    logic [mkc_pkg::CHAR_W-1:0]        char_code;
    logic                              handled;
    logic [mkc_pkg::CHAR_W-1:0]        preedit_code;
    logic                              preedit_valid;
    logic                              last;

    // Composer state as predicted
    logic [mkc_pkg::KEY_W-1:0]   tbl_key  [mkc_pkg::MAX_KEYS];
    logic [mkc_pkg::LEN_W-1:0]   tbl_len  [mkc_pkg::MAX_KEYS];
    logic [mkc_pkg::CHAR_W-1:0]  tbl_char [mkc_pkg::MAX_KEYS*mkc_pkg::MAX_CHARS];
    logic [mkc_pkg::KEY_W-1:0]   held_key;
    int                          held_presses;
    logic [mkc_pkg::CHAR_W-1:0]  held_char;
    logic                        held_valid;
    logic [mkc_pkg::TIMER_W-1:0] ticks_left;
    logic [mkc_pkg::TIMER_W-1:0] timeout_reg;
    logic [mkc_pkg::KEYS_W-1:0]  keys_reg;

    composer_out_t composed_q[$];

    int fail_count     = 0;
    int items_sent     = 0;
    int commits_seen   = 0;
    int status_seen    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;

    multitap_key_composer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .key_code      (key_code),
        .key_char      (key_char),
        .passthrough   (passthrough),
        .slot_index    (slot_index),
        .char_index    (char_index),
        .table_char    (table_char),
        .seq_length    (seq_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .char_code     (char_code),
        .handled       (handled),
        .preedit_code  (preedit_code),
        .preedit_valid (preedit_valid),
        .last          (last)
    );

    always #CLK_HALF clk = ~clk;

    // ---------------------------------------------------------------- prediction

    function automatic void drop_pending();
        held_key     = '0;
        held_presses = 0;
        held_char    = '0;
        held_valid   = 1'b0;
        ticks_left   = '0;
    endfunction

    function automatic void commit_char(input logic [mkc_pkg::CHAR_W-1:0] code);
        composer_out_t res;
        drop_pending();
        res = '{kind: mkc_pkg::KIND_COMMIT, char_code: code, handled: 1'b0,
                preedit_code: '0, preedit_valid: 1'b0, last: 1'b0};
        composed_q.push_back(res);
    endfunction

    function automatic void commit_held();
        if (held_valid)
        begin
            commit_char(held_char);
        end
    endfunction

    function automatic int clamp_len(input logic [mkc_pkg::LEN_W-1:0] len);
        return (int'(len) > mkc_pkg::MAX_CHARS) ? mkc_pkg::MAX_CHARS : int'(len);
    endfunction

    // Lowest matching slot wins; empty slots never match
    function automatic int lookup_slot(input logic [mkc_pkg::KEY_W-1:0] code);
        int lim;
        lim = (int'(keys_reg) > mkc_pkg::MAX_KEYS)
              ? mkc_pkg::MAX_KEYS : int'(keys_reg);
        for (int i = 0; i < lim; i++)
        begin
            if (tbl_key[i] == code && clamp_len(tbl_len[i]) != 0)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void compose_key_event(input key_event_t ev);
        int            s;
        int            cell_idx;
        logic          was_handled;
        composer_out_t res;
        was_handled = 1'b0;
        case (ev.op)
            mkc_pkg::OP_PRESS:
            begin
                if (held_presses > 0 && held_key != ev.key_code)
                begin
                    commit_held();
                end
                s = ev.passthrough ? -1 : lookup_slot(ev.key_code);
                if (s >= 0)
                begin
                    // wrap to the first candidate without a commit
                    if (held_presses >= clamp_len(tbl_len[s]))
                    begin
                        drop_pending();
                    end
                    held_key = ev.key_code;
                    held_presses++;
                    held_char = tbl_char[s*mkc_pkg::MAX_CHARS + held_presses - 1];
                    held_valid = 1'b1;
                    ticks_left = (timeout_reg == 0) ? mkc_pkg::TIMER_W'(1) : timeout_reg;
                    was_handled = 1'b1;
                end
                else
                begin
                    if (held_presses > 0)
                    begin
                        commit_held();
                    end
                    if (ev.key_char != 0)
                    begin
                        commit_char(ev.key_char);
                        was_handled = 1'b1;
                    end
                end
            end
            mkc_pkg::OP_TICK:
            begin
                if (ticks_left != 0)
                begin
                    ticks_left--;
                    if (ticks_left == 0)
                    begin
                        if (held_valid)
                        begin
                            commit_char(held_char);
                        end
                        else
                        begin
                            drop_pending();
                        end
                    end
                end
            end
            mkc_pkg::OP_RESET:
            begin
                drop_pending();
            end
            mkc_pkg::OP_LOAD:
            begin
                cell_idx = int'(ev.slot_index) * mkc_pkg::MAX_CHARS + int'(ev.char_index);
                tbl_char[cell_idx] = ev.table_char;
                if (ev.char_index == 0)
                begin
                    tbl_key[ev.slot_index] = mkc_pkg::KEY_W'(ev.table_char);
                end
                tbl_len[ev.slot_index] = ev.seq_length;
            end
            default:
            begin
            end
        endcase
        res = '{kind: mkc_pkg::KIND_STATUS, char_code: '0, handled: was_handled,
                preedit_code: held_valid ? held_char : '0,
                preedit_valid: held_valid, last: 1'b1};
        composed_q.push_back(res);
    endfunction

    // ---------------------------------------------------------------- item builders

    function automatic logic [mkc_pkg::CHAR_W-1:0] rand_char();
        return ($urandom_range(0, 3) == 0) ? '0 : mkc_pkg::CHAR_W'($urandom);
    endfunction

    function automatic key_event_t rand_event();
        key_event_t ev;
        ev.op          = mkc_pkg::OP_W'($urandom_range(0, 7));
        ev.key_code    = mkc_pkg::KEY_W'($urandom);
        ev.key_char    = rand_char();
        ev.passthrough = 1'($urandom_range(0, 1));
        ev.slot_index  = mkc_pkg::SLOT_IN_W'($urandom);
        ev.char_index  = mkc_pkg::CIDX_IN_W'($urandom);
        ev.table_char  = mkc_pkg::CHAR_W'($urandom);
        ev.seq_length  = mkc_pkg::LEN_W'($urandom);
        return ev;
    endfunction

    function automatic key_event_t press_ev(input logic [mkc_pkg::KEY_W-1:0] code,
                                            input logic [mkc_pkg::CHAR_W-1:0] ch,
                                            input logic pass);
        key_event_t ev;
        ev             = rand_event();
        ev.op          = mkc_pkg::OP_PRESS;
        ev.key_code    = code;
        ev.key_char    = ch;
        ev.passthrough = pass;
        return ev;
    endfunction

    function automatic key_event_t op_ev(input logic [mkc_pkg::OP_W-1:0] code);
        key_event_t ev;
        ev    = rand_event();
        ev.op = code;
        return ev;
    endfunction

    function automatic key_event_t load_ev(input int slot, input int cidx,
                                           input logic [mkc_pkg::CHAR_W-1:0] ch,
                                           input logic [mkc_pkg::LEN_W-1:0] len);
        key_event_t ev;
        ev            = rand_event();
        ev.op         = mkc_pkg::OP_LOAD;
        ev.slot_index = mkc_pkg::SLOT_IN_W'(slot);
        ev.char_index = mkc_pkg::CIDX_IN_W'(cidx);
        ev.table_char = ch;
        ev.seq_length = len;
        return ev;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_event(input key_event_t ev);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        op          <= ev.op;
        key_code    <= ev.key_code;
        key_char    <= ev.key_char;
        passthrough <= ev.passthrough;
        slot_index  <= ev.slot_index;
        char_index  <= ev.char_index;
        table_char  <= ev.table_char;
        seq_length  <= ev.seq_length;
        in_valid    <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        compose_key_event(ev);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (composed_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_config(input logic [mkc_pkg::CFG_DATA_W-1:0] tmo,
                              input logic [mkc_pkg::CFG_DATA_W-1:0] keys);
        wait_drained();
        cfg_index <= mkc_pkg::CFG_TIMEOUT;
        cfg_data  <= tmo;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        timeout_reg = tmo;
        cfg_index <= mkc_pkg::CFG_KEYS;
        cfg_data  <= keys;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        keys_reg = mkc_pkg::KEYS_W'(keys);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver and checker

    function automatic void compare_field(input string name,
                                          input logic [mkc_pkg::CHAR_W-1:0] want,
                                          input logic [mkc_pkg::CHAR_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_output();
        composer_out_t want;
        if (composed_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual kind %0d char %h last %0d",
                     $time, kind, char_code, last);
            fail_count++;
        end
        else
        begin
            want = composed_q.pop_front();
            compare_field("kind", mkc_pkg::CHAR_W'(want.kind), mkc_pkg::CHAR_W'(kind));
            compare_field("char_code", want.char_code, char_code);
            compare_field("handled", mkc_pkg::CHAR_W'(want.handled),
                          mkc_pkg::CHAR_W'(handled));
            compare_field("preedit_code", want.preedit_code, preedit_code);
            compare_field("preedit_valid", mkc_pkg::CHAR_W'(want.preedit_valid),
                          mkc_pkg::CHAR_W'(preedit_valid));
            compare_field("last", mkc_pkg::CHAR_W'(want.last), mkc_pkg::CHAR_W'(last));
        end
        if (kind == mkc_pkg::KIND_COMMIT)
        begin
            commits_seen++;
        end
        else
        begin
            status_seen++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_output();
        end
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- tests

    // Fill every slot and candidate so that no lookup reads an unwritten entry
    task automatic load_key_table();
        logic [mkc_pkg::CHAR_W-1:0] slot_key [mkc_pkg::MAX_KEYS];
        logic [mkc_pkg::LEN_W-1:0]  len;
        for (int s = 0; s < mkc_pkg::MAX_KEYS; s++)
        begin
            slot_key[s] = mkc_pkg::CHAR_W'($urandom);
        end
        slot_key[0]  = '1;
        slot_key[9]  = slot_key[5];
        slot_key[15] = '0;
        for (int s = 0; s < mkc_pkg::MAX_KEYS; s++)
        begin
            case (s)
                0:       len = mkc_pkg::LEN_W'(3);
                2:       len = mkc_pkg::LEN_W'(0);
                3:       len = mkc_pkg::LEN_W'(15);
                4:       len = mkc_pkg::LEN_W'(1);
                default: len = mkc_pkg::LEN_W'($urandom_range(1, mkc_pkg::MAX_CHARS));
            endcase
            for (int c = mkc_pkg::MAX_CHARS - 1; c >= 0; c--)
            begin
                send_event(load_ev(s, c, (c == 0) ? slot_key[s]
                                                  : mkc_pkg::CHAR_W'($urandom), len));
            end
        end
    endtask

    task automatic test_multitap_steps();
        set_config(16'd1000, 16'd16);
        // stepping wraps after the third candidate
        repeat (4) send_event(press_ev(tbl_key[0], rand_char(), 1'b0));
        // duplicate key: the lower slot is used
        send_event(press_ev(tbl_key[5], rand_char(), 1'b0));
        // empty slot acts as a plain key with the widest code point
        send_event(press_ev(tbl_key[2], '1, 1'b0));
        send_event(press_ev(tbl_key[1], rand_char(), 1'b0));
        send_event(press_ev(tbl_key[1], '0, 1'b1));
        repeat (2) send_event(press_ev(tbl_key[4], rand_char(), 1'b0));
        send_event(press_ev('1, '0, 1'b0));
        send_event(press_ev(tbl_key[15], '0, 1'b0));
        send_event(op_ev(OP_OTHER));
        send_event(op_ev(mkc_pkg::OP_RESET));
        for (int o = OP_SPARE_LO; o <= OP_SPARE_HI; o++)
        begin
            send_event(op_ev(mkc_pkg::OP_W'(o)));
        end
    endtask

    task automatic test_keys_in_use();
        set_config(16'd1000, 16'd0);
        send_event(press_ev(tbl_key[0], mkc_pkg::CHAR_W'($urandom), 1'b0));
        set_config(16'd1000, 16'hFFF1);
        send_event(press_ev(tbl_key[15], rand_char(), 1'b0));
    endtask

    task automatic test_timeout();
        set_config(16'd0, 16'd16);
        send_event(press_ev(tbl_key[1], rand_char(), 1'b0));
        send_event(op_ev(mkc_pkg::OP_TICK));
        send_event(op_ev(mkc_pkg::OP_TICK));
        set_config(16'd2, 16'd16);
        send_event(press_ev(tbl_key[6], rand_char(), 1'b0));
        send_event(op_ev(mkc_pkg::OP_TICK));
        send_event(press_ev(tbl_key[6], rand_char(), 1'b0));
        repeat (2) send_event(op_ev(mkc_pkg::OP_TICK));
        set_config(16'hFFFF, 16'd16);
        send_event(press_ev(tbl_key[7], rand_char(), 1'b0));
        send_event(op_ev(mkc_pkg::OP_TICK));
        send_event(op_ev(mkc_pkg::OP_RESET));
    endtask

    // Mostly multi-tap words on loaded keys, the rest stray events
    task automatic random_traffic(input int n);
        int         done_items;
        int         pick;
        int         lim;
        int         s;
        int         presses;
        int         burst;
        int         tmo;
        key_event_t ev;
        done_items = 0;
        while (done_items < n)
        begin
            pick = $urandom_range(0, 99);
            lim  = (int'(keys_reg) > mkc_pkg::MAX_KEYS) ? mkc_pkg::MAX_KEYS : int'(keys_reg);
            if (pick < 60)
            begin
                s = (lim == 0) ? $urandom_range(0, mkc_pkg::MAX_KEYS - 1)
                               : $urandom_range(0, lim - 1);
                presses = $urandom_range(1, clamp_len(tbl_len[s]) + 2);
                repeat (presses) send_event(press_ev(tbl_key[s], rand_char(), 1'b0));
                done_items += presses;
                if ($urandom_range(0, 2) == 0)
                begin
                    tmo   = (timeout_reg == 0) ? 1 : int'(timeout_reg);
                    burst = (tmo <= 8) ? $urandom_range(1, tmo + 1) : $urandom_range(1, 3);
                    repeat (burst) send_event(op_ev(mkc_pkg::OP_TICK));
                    done_items += burst;
                end
            end
            else
            begin
                ev = rand_event();
                if (pick < 70)
                begin
                    ev.op = mkc_pkg::OP_PRESS;
                end
                else if (pick < 75)
                begin
                    ev = press_ev(tbl_key[$urandom_range(0, mkc_pkg::MAX_KEYS - 1)],
                                  rand_char(), 1'b1);
                end
                else if (pick < 82)
                begin
                    ev.op = mkc_pkg::OP_TICK;
                end
                else if (pick < 86)
                begin
                    ev.op = OP_OTHER;
                end
                else if (pick < 89)
                begin
                    ev.op = mkc_pkg::OP_RESET;
                end
                else if (pick < 96)
                begin
                    ev.op = mkc_pkg::OP_LOAD;
                end
                else
                begin
                    ev.op = mkc_pkg::OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                end
                send_event(ev);
                done_items++;
            end
        end
    endtask

    // Output held off long enough for the block to back up into its input
    task automatic test_long_hold();
        set_config(16'd3, 16'd16);
        hold_requests++;
        random_traffic(16);
        wait_drained();
    endtask

    task automatic run_random_phase(input logic [mkc_pkg::CFG_DATA_W-1:0] tmo,
                                    input logic [mkc_pkg::CFG_DATA_W-1:0] keys,
                                    input int idle_pct, input int stall_pct);
        set_config(tmo, keys);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        random_traffic(PHASE_ITEMS);
    endtask

    initial
    begin
        for (int i = 0; i < mkc_pkg::MAX_KEYS * mkc_pkg::MAX_CHARS; i++)
        begin
            tbl_char[i] = '0;
        end
        for (int i = 0; i < mkc_pkg::MAX_KEYS; i++)
        begin
            tbl_key[i] = '0;
            tbl_len[i] = '0;
        end
        drop_pending();
        timeout_reg = mkc_pkg::TIMEOUT_RESET;
        keys_reg    = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        load_key_table();
        test_multitap_steps();
        test_keys_in_use();
        test_timeout();
        test_long_hold();
        run_random_phase(16'd3, 16'd16, 0, 0);
        run_random_phase(16'd1, 16'hFFFF, 49, 0);
        run_random_phase(16'd6, 16'd7, 0, 49);
        run_random_phase(16'd0, 16'hA00C, 20, 20);
        wait_drained();

        $display("Drove %0d items (table fill, directed, long hold, four idle mixes),",
                 items_sent);
        $display("checked %0d commits and %0d status results.", commits_seen, status_seen);
        if (fail_count == 0)
        begin
            $display("multitap_key_composer_top test passed");
        end
        else
        begin
            $display("multitap_key_composer_top test failed");
        end
        $finish;
    end

    initial
    begin
        #10000000;
        $display("%0t: timeout with %0d results outstanding", $time, composed_q.size());
        $display("multitap_key_composer_top test failed");
        $finish;
    end

endmodule
